// ===== sv/lld3_pkg.sv =====
package lld3_pkg;

  localparam int GAP_BITS = 24;
  localparam int TOL_BITS = 16;
  localparam logic [TOL_BITS-1:0] TOL_RESET = 16'd16;
  localparam int NUM_FIELDS = 12;

endpackage

// ===== sv/lld3_geom.sv =====
module lld3_geom #(
  parameter int CW = 16
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      en,
  input  logic                      in_valid,
  input  logic [12*CW-1:0]          in_data,
  output logic                      out_valid,
  output logic signed [4*CW+3:0]    det,
  output logic signed [3*CW+2:0]    p,
  output logic signed [4*CW+3:0]    cq [3],
  output logic signed [2*CW+3:0]    usum,
  output logic signed [2*CW+1:0]    a
);

  localparam int XW   = 2 * CW + 2;
  localparam int SQW  = 2 * XW;
  localparam int USW  = 2 * CW + 4;
  localparam int PPW  = 3 * CW + 3;
  localparam int DETW = 4 * CW + 4;

  logic signed [CW-1:0] f [lld3_pkg::NUM_FIELDS];

  always_comb begin
    for (int i = 0; i < lld3_pkg::NUM_FIELDS; i++) begin
      f[i] = in_data[i*CW +: CW];
    end
  end

  logic                 v1, v2, v3;
  logic signed [XW-1:0] dd [9];
  logic signed [XW-1:0] np [6];
  logic signed [CW:0]   u1 [3];
  logic signed [CW-1:0] d1 [3];

  logic signed [XW-1:0] a2, b2, c2;
  logic signed [XW-1:0] n2 [3];
  logic signed [XW-1:0] up [6];
  logic signed [USW-1:0] uq [3];
  logic signed [CW:0]   u2 [3];

  logic signed [DETW-1:0] ac, bb;
  logic signed [PPW-1:0]  un [3];
  logic signed [XW-1:0]   cr [3];
  logic signed [USW-1:0]  usum3;
  logic signed [XW-1:0]   a3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      out_valid <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        dd[i]   <= f[3+i] * f[3+i];
        dd[3+i] <= f[3+i] * f[9+i];
        dd[6+i] <= f[9+i] * f[9+i];
        u1[i]   <= (CW+1)'(f[6+i]) - (CW+1)'(f[i]);
        d1[i]   <= f[3+i];
      end
      np[0] <= f[4] * f[11];
      np[1] <= f[5] * f[10];
      np[2] <= f[5] * f[9];
      np[3] <= f[3] * f[11];
      np[4] <= f[3] * f[10];
      np[5] <= f[4] * f[9];

      a2 <= dd[0] + dd[1] + dd[2];
      b2 <= dd[3] + dd[4] + dd[5];
      c2 <= dd[6] + dd[7] + dd[8];
      n2[0] <= np[0] - np[1];
      n2[1] <= np[2] - np[3];
      n2[2] <= np[4] - np[5];
      up[0] <= u1[1] * d1[2];
      up[1] <= u1[2] * d1[1];
      up[2] <= u1[2] * d1[0];
      up[3] <= u1[0] * d1[2];
      up[4] <= u1[0] * d1[1];
      up[5] <= u1[1] * d1[0];
      for (int i = 0; i < 3; i++) begin
        uq[i] <= u1[i] * u1[i];
        u2[i] <= u1[i];
      end

      ac <= a2 * c2;
      bb <= b2 * b2;
      for (int i = 0; i < 3; i++) begin
        un[i] <= u2[i] * n2[i];
      end
      cr[0] <= up[0] - up[1];
      cr[1] <= up[2] - up[3];
      cr[2] <= up[4] - up[5];
      usum3 <= uq[0] + uq[1] + uq[2];
      a3 <= a2;

      det <= ac - bb;
      p <= un[0] + un[1] + un[2];
      for (int i = 0; i < 3; i++) begin
        cq[i] <= SQW'(cr[i]) * SQW'(cr[i]);
      end
      usum <= usum3;
      a <= a3;
    end
  end

endmodule

// ===== sv/lld3_select.sv =====
module lld3_select #(
  parameter int CW = 16,
  parameter int FRAC = 8,
  parameter int RW = 114,
  parameter int DENW = 67
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                en,
  input  logic [lld3_pkg::TOL_BITS-1:0]       tol,
  input  logic                                in_valid,
  input  logic signed [4*CW+3:0]              det,
  input  logic signed [3*CW+2:0]              p,
  input  logic signed [4*CW+3:0]              cq [3],
  input  logic signed [2*CW+3:0]              usum,
  input  logic signed [2*CW+1:0]              a,
  output logic                                out_valid,
  output logic                                out_par,
  output logic [RW-1:0]                       num,
  output logic [DENW-1:0]                     den
);

  localparam int PPW = 3 * CW + 3;
  localparam int SQW = 4 * CW + 4;
  localparam int TSH = 3 * FRAC;
  localparam int TCW = (DENW > lld3_pkg::TOL_BITS + TSH ? DENW : lld3_pkg::TOL_BITS + TSH) + 1;
  localparam int H = (PPW + 1) / 2;
  localparam int HI = PPW - H;

  logic [TCW-1:0] det_c, tol_c;
  logic [PPW-1:0] pm;

  assign det_c = TCW'(det[DENW-1:0]);
  assign tol_c = TCW'(tol) << TSH;
  assign pm = p[PPW-1] ? PPW'(-p) : PPW'(p);

  logic                 v5, par5, az5;
  logic [DENW-1:0]      a5, det5;
  logic [2*HI-1:0]      hh;
  logic [HI+H-1:0]      hl;
  logic [2*H-1:0]       ll;
  logic signed [SQW+1:0] csum;
  logic signed [2*CW+3:0] us5;

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v5 <= in_valid;
      out_valid <= v5;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      par5 <= det_c <= tol_c;
      az5 <= a == '0;
      a5 <= DENW'($unsigned(a));
      det5 <= det[DENW-1:0];
      hh <= pm[PPW-1:H] * pm[PPW-1:H];
      hl <= pm[PPW-1:H] * pm[H-1:0];
      ll <= pm[H-1:0] * pm[H-1:0];
      csum <= (SQW+2)'(cq[0]) + (SQW+2)'(cq[1]) + (SQW+2)'(cq[2]);
      us5 <= usum;

      out_par <= par5;
      if (par5) begin
        if (az5) begin
          num <= RW'($unsigned(us5));
          den <= DENW'(1);
        end else begin
          num <= RW'($unsigned(csum));
          den <= a5;
        end
      end else begin
        num <= (RW'(hh) << (2*H)) + (RW'(hl) << (H+1)) + RW'(ll);
        den <= det5;
      end
    end
  end

endmodule

// ===== sv/lld3_root.sv =====
module lld3_root #(
  parameter int RW = 114,
  parameter int DENW = 67
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              en,
  input  logic                              in_valid,
  input  logic                              in_par,
  input  logic [RW-1:0]                     num,
  input  logic [DENW-1:0]                   den,
  output logic                              out_valid,
  output logic                              out_par,
  output logic                              out_sat,
  output logic [lld3_pkg::GAP_BITS-1:0]     root
);

  localparam int GB = lld3_pkg::GAP_BITS;
  localparam int TW = DENW + GB;

  logic          v   [GB+1];
  logic          par [GB+1];
  logic          sat [GB+1];
  logic [RW-1:0] rem [GB+1];
  logic [TW-1:0] tt  [GB+1];
  logic [DENW-1:0] dn [GB+1];
  logic [GB-1:0] rr  [GB+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v[0] <= 1'b0;
    end else if (en) begin
      v[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      par[0] <= in_par;
      sat[0] <= (RW'(den) << (2*GB)) <= num;
      rem[0] <= num;
      tt[0] <= '0;
      dn[0] <= den;
      rr[0] <= '0;
    end
  end

  for (genvar j = 0; j < GB; j++) begin : g_bit
    localparam int K = GB - 1 - j;
    logic [RW-1:0] dl;
    logic          take;

    assign dl = (RW'(tt[j]) << (K+1)) + (RW'(dn[j]) << (2*K));
    assign take = dl <= rem[j];

    always_ff @(posedge clk) begin
      if (rst) begin
        v[j+1] <= 1'b0;
      end else if (en) begin
        v[j+1] <= v[j];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        par[j+1] <= par[j];
        sat[j+1] <= sat[j];
        dn[j+1] <= dn[j];
        if (take) begin
          rem[j+1] <= rem[j] - dl;
          tt[j+1] <= tt[j] + (TW'(dn[j]) << K);
          rr[j+1] <= rr[j] | (GB'(1) << K);
        end else begin
          rem[j+1] <= rem[j];
          tt[j+1] <= tt[j];
          rr[j+1] <= rr[j];
        end
      end
    end
  end

  assign out_valid = v[GB];
  assign out_par = par[GB];
  assign out_sat = sat[GB];
  assign root = sat[GB] ? '1 : rr[GB];

endmodule

// ===== sv/line_line_distance_3d_core.sv =====
// Shortest distance between two 3D lines, each given as a start point and a direction in
// signed fixed point. One pair of lines is accepted every cycle while the output is not
// stalled. Four stages form the dot and cross products and the determinant, two stages
// pick the parallel or general case and build the squared numerator, a square root of
// the ratio takes one stage per result bit, 24 in all plus its saturation check, and one
// output register follows. A stall on the output holds the whole pipeline.
// The tolerance register is written through the cfg channel; the user must write it only
// while the block is idle, as the block itself does not enforce this.
module line_line_distance_3d_core #(
  parameter int COORD_WIDTH = 16,
  parameter int FRAC_BITS = 8
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  s_tvalid,
  output logic                                  s_tready,
  // line1_start_x/y/z, line1_dir_x/y/z, line2_start_x/y/z, line2_dir_x/y/z from bit 0 up.
  input  logic [((12*COORD_WIDTH+7)/8)*8-1:0]   s_tdata,
  output logic                                  m_tvalid,
  input  logic                                  m_tready,
  // gap_length.
  output logic [lld3_pkg::GAP_BITS-1:0]         m_tdata,
  // lines_parallel, saturated from bit 0 up.
  output logic [1:0]                            m_tuser,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [lld3_pkg::TOL_BITS-1:0]         cfg_data
);

  localparam int CW = COORD_WIDTH;
  localparam int PPW = 3 * CW + 3;
  localparam int DENW = 4 * CW + 3;
  localparam int GB = lld3_pkg::GAP_BITS;
  localparam int RW = (2*PPW > DENW + 2*GB ? 2*PPW : DENW + 2*GB) + 1;

  logic en;
  logic [lld3_pkg::TOL_BITS-1:0] tol;

  assign en = !m_tvalid || m_tready;
  assign s_tready = en;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      tol <= lld3_pkg::TOL_RESET;
    end else if (cfg_valid) begin
      tol <= cfg_data;
    end
  end

  logic                     g_valid;
  logic signed [4*CW+3:0]   g_det;
  logic signed [3*CW+2:0]   g_p;
  logic signed [4*CW+3:0]   g_cq [3];
  logic signed [2*CW+3:0]   g_usum;
  logic signed [2*CW+1:0]   g_a;

  lld3_geom #(.CW(CW)) u_geom (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(s_tvalid), .in_data(s_tdata[12*CW-1:0]),
    .out_valid(g_valid), .det(g_det), .p(g_p), .cq(g_cq), .usum(g_usum), .a(g_a)
  );

  logic            s_valid, s_par;
  logic [RW-1:0]   s_num;
  logic [DENW-1:0] s_den;

  lld3_select #(.CW(CW), .FRAC(FRAC_BITS), .RW(RW), .DENW(DENW)) u_select (
    .clk(clk), .rst(rst), .en(en), .tol(tol),
    .in_valid(g_valid), .det(g_det), .p(g_p), .cq(g_cq), .usum(g_usum), .a(g_a),
    .out_valid(s_valid), .out_par(s_par), .num(s_num), .den(s_den)
  );

  logic          r_valid, r_par, r_sat;
  logic [GB-1:0] r_root;

  lld3_root #(.RW(RW), .DENW(DENW)) u_root (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(s_valid), .in_par(s_par), .num(s_num), .den(s_den),
    .out_valid(r_valid), .out_par(r_par), .out_sat(r_sat), .root(r_root)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en) begin
      m_tvalid <= r_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_tdata <= r_root;
      m_tuser <= {r_sat, r_par};
    end
  end

endmodule

// ===== bench/line_line_distance_3d_core_test.sv =====
`timescale 1ns / 100ps

class gap_scoreboard;
  logic [15:0] tolerance;
  int errors;
  logic [23:0] gap_q[$];
  bit par_q[$];
  bit sat_q[$];

  function new();
    tolerance = lld3_pkg::TOL_RESET;
    errors = 0;
  endfunction

  static function logic [127:0] mag(longint v);
    longint m;
    m = (v < 0) ? -v : v;
    return 128'(unsigned'(m));
  endfunction

  static function logic [127:0] sq3(longint x, longint y, longint z);
    return mag(x) * mag(x) + mag(y) * mag(y) + mag(z) * mag(z);
  endfunction

  // Largest r below 2^24 with r*r*den <= num.
  static function logic [23:0] isqrt_ratio(logic [127:0] num, logic [127:0] den,
                                           output bit sat);
    logic [127:0] r;
    logic [127:0] cand;
    sat = 0;
    if (((128'd1 << 48) * den) <= num) begin
      sat = 1;
      return 24'hFFFFFF;
    end
    r = 0;
    for (int bitpos = 23; bitpos >= 0; bitpos--) begin
      cand = r | (128'd1 << bitpos);
      if (cand * cand * den <= num) r = cand;
    end
    return r[23:0];
  endfunction

  function void note_lines(logic [191:0] beat);
    longint f[12];
    longint a, b, c, ux, uy, uz, cx, cy, cz, nx, ny, nz, p;
    logic [127:0] det;
    bit par, sat;
    logic [23:0] gap;
    for (int i = 0; i < 12; i++) f[i] = longint'($signed(beat[16*i +: 16]));
    a = f[3] * f[3] + f[4] * f[4] + f[5] * f[5];
    b = f[3] * f[9] + f[4] * f[10] + f[5] * f[11];
    c = f[9] * f[9] + f[10] * f[10] + f[11] * f[11];
    det = 128'(unsigned'(a)) * 128'(unsigned'(c)) - mag(b) * mag(b);
    par = det <= (128'(tolerance) << 24);
    if (par) begin
      ux = f[6] - f[0];
      uy = f[7] - f[1];
      uz = f[8] - f[2];
      if (a == 0) begin
        gap = isqrt_ratio(sq3(ux, uy, uz), 128'd1, sat);
      end else begin
        cx = uy * f[5] - uz * f[4];
        cy = uz * f[3] - ux * f[5];
        cz = ux * f[4] - uy * f[3];
        gap = isqrt_ratio(sq3(cx, cy, cz), 128'(unsigned'(a)), sat);
      end
    end else begin
      nx = f[4] * f[11] - f[5] * f[10];
      ny = f[5] * f[9] - f[3] * f[11];
      nz = f[3] * f[10] - f[4] * f[9];
      p = (f[0] - f[6]) * nx + (f[1] - f[7]) * ny + (f[2] - f[8]) * nz;
      gap = isqrt_ratio(mag(p) * mag(p), det, sat);
    end
    gap_q.push_back(gap);
    par_q.push_back(par);
    sat_q.push_back(sat);
  endfunction

  function void check_gap(logic [23:0] gap, logic par, logic sat);
    logic [23:0] eg;
    bit ep, es;
    if (gap_q.size() == 0) begin
      $error("unexpected result beat gap_length=%0d", gap);
      errors++;
      return;
    end
    eg = gap_q.pop_front();
    ep = par_q.pop_front();
    es = sat_q.pop_front();
    if (gap !== eg) begin
      $error("gap_length expected %0d actual %0d", eg, gap);
      errors++;
    end
    if (par !== ep) begin
      $error("lines_parallel expected %0d actual %0d", ep, par);
      errors++;
    end
    if (sat !== es) begin
      $error("saturated expected %0d actual %0d", es, sat);
      errors++;
    end
  endfunction
endclass

module line_line_distance_3d_core_test;
  logic clk = 0;
  logic rst = 1;
  logic s_tvalid = 0;
  logic s_tready;
  logic [191:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 0;
  logic [23:0] m_tdata;
  logic [1:0] m_tuser;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic [15:0] cfg_data = '0;

  gap_scoreboard sb = new();
  bit tx_steady = 0;
  bit rx_steady = 0;
  bit stim_done = 0;

  always begin
    #10 clk = 1;
    #10 clk = 0;
  end

  line_line_distance_3d_core i_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always @(posedge clk) begin
    if (!rst && s_tvalid && s_tready) sb.note_lines(s_tdata);
    if (!rst && m_tvalid && m_tready) sb.check_gap(m_tdata, m_tuser[0], m_tuser[1]);
  end

  initial begin
    int g;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      g = rx_steady ? 0 : $urandom_range(0, 13);
      if (g > 0) begin
        m_tready = 0;
        repeat (g) @(negedge clk);
      end
      m_tready = 1;
      do @(posedge clk); while (!m_tvalid);
      @(negedge clk);
    end
  end

  function automatic logic [191:0] pack_lines(int v[12]);
    logic [191:0] beat;
    for (int i = 0; i < 12; i++) beat[16*i +: 16] = 16'(v[i]);
    return beat;
  endfunction

  task automatic send_lines(logic [191:0] beat);
    int g;
    g = tx_steady ? 0 : $urandom_range(0, 13);
    if (g > 0) begin
      s_tvalid = 0;
      repeat (g) @(negedge clk);
    end
    s_tdata = beat;
    s_tvalid = 1;
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
  endtask

  task automatic drain();
    s_tvalid = 0;
    while (sb.gap_q.size() != 0) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  task automatic write_tolerance(logic [15:0] value);
    cfg_data = value;
    cfg_valid = 1;
    do @(posedge clk); while (!cfg_ready);
    sb.tolerance = value;
    @(negedge clk);
    cfg_valid = 0;
  endtask

  task automatic send_directed();
    int v[12];
    v = '{0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0};
    send_lines(pack_lines(v));
    v = '{32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767};
    send_lines(pack_lines(v));
    v = '{-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768,
          -32768, -32768};
    send_lines(pack_lines(v));
    // Line 1 has no direction.
    v = '{100, -200, 300, 0, 0, 0, -5000, 7000, 32767, 256, 0, 0};
    send_lines(pack_lines(v));
    v = '{-32768, -32768, -32768, 0, 0, 0, 32767, 32767, 32767, 0, 0, 0};
    send_lines(pack_lines(v));
    // Parallel lines.
    v = '{0, 0, 0, 256, 512, 0, 1000, -300, 256, 512, 1024, 0};
    send_lines(pack_lines(v));
    // Skew, perpendicular lines.
    v = '{0, 0, 0, 256, 0, 0, 0, 0, 2560, 0, 256, 0};
    send_lines(pack_lines(v));
    // Determinant exactly at the tolerance of 16, then just above it.
    v = '{0, 0, 0, 256, 0, 0, 0, 0, 1000, 0, 64, 0};
    send_lines(pack_lines(v));
    v = '{0, 0, 0, 256, 0, 0, 0, 0, 1000, 0, 65, 0};
    send_lines(pack_lines(v));
    // Extreme coordinate values.
    v = '{-32768, -32768, -32768, 1, 0, 0, 32767, 32767, 32767, 0, 1, 0};
    send_lines(pack_lines(v));
    v = '{-32768, -32768, -32768, -32768, 0, 0, 32767, 32767, 32767, 0, -32768, 0};
    send_lines(pack_lines(v));
    v = '{-32768, 32767, -32768, 1, 0, 0, 32767, -32768, 32767, 1, 0, 0};
    send_lines(pack_lines(v));
    v = '{0, 0, 0, 32767, -32768, 32767, 0, 0, 0, -32768, 32767, -32768};
    send_lines(pack_lines(v));
  endtask

  task automatic send_random(int count);
    int v[12];
    int k;
    for (int n = 0; n < count; n++) begin
      if (n % 100 == 0) begin
        tx_steady = ($urandom_range(0, 3) == 0);
        rx_steady = ($urandom_range(0, 3) == 0);
      end
      for (int i = 0; i < 12; i++) v[i] = $urandom_range(0, 65535) - 32768;
      case ($urandom_range(0, 5))
        0: begin
          for (int i = 3; i < 6; i++) v[i] = $urandom_range(0, 8) - 4;
          for (int i = 9; i < 12; i++) v[i] = $urandom_range(0, 8) - 4;
        end
        1: begin
          k = $urandom_range(0, 6) - 3;
          for (int i = 3; i < 6; i++) begin
            v[i] = $urandom_range(0, 4000) - 2000;
            v[i+6] = k * v[i] + $urandom_range(0, 2) - 1;
          end
        end
        2: begin
          v[3] = 0;
          v[4] = 0;
          v[5] = 0;
        end
        3: begin
          for (int i = 0; i < 12; i++) v[i] = $urandom_range(0, 2000) - 1000;
        end
        default: ;
      endcase
      send_lines(pack_lines(v));
    end
    tx_steady = 0;
    rx_steady = 0;
  endtask

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 0;
    write_tolerance(16'd16);
    send_directed();
    send_random(330);
    drain();
    write_tolerance(16'd0);
    send_directed();
    send_random(330);
    drain();
    write_tolerance(16'hFFFF);
    send_directed();
    send_random(330);
    drain();
    write_tolerance(16'($urandom_range(1, 65534)));
    send_random(330);
    drain();
    write_tolerance(16'd1);
    send_random(330);
    drain();
    if (sb.errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("Mismatches found");
    $finish;
  end
endmodule
